[rtl/core/jic_pkg.sv]
// Shared types, constants and arithmetic helpers of the joystick input conditioner.
// Used by jic_ctrl, jic_dp and joystick_input_conditioner; depends on nothing.
package jic_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  // Fixed steering deadzone of 0.005, rounded to the fraction grid.
  localparam int SDZ       = (5 * ONE + 500) / 1000;

  localparam int DIV_W     = 29;  // divider numerator and quotient width
  localparam int SQ_W      = 29;  // square root radicand width

  localparam logic [3:0] IDX_INT_LO  = 4'd12;
  localparam logic [3:0] IDX_INT_HI  = 4'd14;
  localparam logic [3:0] IDX_FRAC_HI = 4'd11;

  typedef enum logic [2:0] {
    CFG_RATE   = 3'd0,
    CFG_SLEW   = 3'd1,
    CFG_EXP    = 3'd2,
    CFG_TH_DZ  = 3'd3,
    CFG_BR_DZ  = 3'd4
  } jic_cfg_e;

  typedef enum logic [2:0] {
    DV_SSTEP,
    DV_PSTEP,
    DV_DST,
    DV_DTH,
    DV_DBR
  } jic_div_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SSTEP,
    S_SSTEP_W,
    S_PSTEP,
    S_PSTEP_W,
    S_SLEW,
    S_DST,
    S_DST_W,
    S_DTH,
    S_DTH_W,
    S_DBR,
    S_DBR_W,
    S_CINIT,
    S_MRP,
    S_SQP,
    S_SQRT,
    S_SQRT_W,
    S_MRS,
    S_OUT
  } jic_state_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    jic_div_e div_sel;
    logic     slew;
    logic     curve_init;
    logic     mul_rp;
    logic     sq_p;
    logic     sqrt_start;
    logic     mul_rs;
    logic [3:0] bit_idx;
    logic     out_load;
  } jic_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
  } jic_stat_t;

  // Fixed-point product of two values no larger than ONE, rounded half up.
  function automatic logic [14:0] qmul_f(logic [14:0] a, logic [14:0] b);
    logic [30:0] prod;
    prod = 31'(a) * 31'(b) + 31'(ONE / 2);
    return prod[FRAC_BITS +: 15];
  endfunction

  // Limits the move from prev to cur to at most step in either direction.
  function automatic logic signed [19:0] slew_f(logic signed [19:0] cur,
                                                logic signed [19:0] prev,
                                                logic signed [19:0] step);
    logic signed [19:0] d;
    logic signed [19:0] r;
    d = cur - prev;
    if (d > step) begin
      r = prev + step;
    end else if (d < -step) begin
      r = prev - step;
    end else begin
      r = cur;
    end
    return r;
  endfunction

endpackage

[rtl/core/jic_dp.sv]
// Datapath of the joystick input conditioner: registers, clamp, slew, divider,
// square root unit, multiplier and result registers. Depends on jic_pkg.
module jic_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [2:0]             cfg_index_i,
  input  logic [14:0]            cfg_data_i,
  input  logic signed [15:0]     steering_in_i,
  input  logic signed [15:0]     throttle_in_i,
  input  logic signed [15:0]     brake_in_i,
  input  logic signed [15:0]     speed_in_i,
  input  logic                   stamp_valid_i,
  input  jic_pkg::jic_cmd_t      cmd_i,
  output jic_pkg::jic_stat_t     stat_o,
  output logic signed [15:0]     steering_out_o,
  output logic [14:0]            throttle_out_o,
  output logic [14:0]            brake_out_o,
  output logic [14:0]            speed_out_o
);

  localparam logic signed [15:0] ONE_S = 16'(jic_pkg::ONE);
  localparam logic [14:0]        ONE_U = 15'(jic_pkg::ONE);
  localparam logic [15:0]        ONE_W = 16'(jic_pkg::ONE);
  localparam logic [14:0]        SDZ_U = 15'(jic_pkg::SDZ);

  // Configuration registers.
  logic [9:0]  rate_q;
  logic        slew_en_q;
  logic [14:0] exp_q;
  logic [14:0] tdz_q;
  logic [14:0] bdz_q;

  // Slew history.
  logic signed [15:0] prev_st_q;
  logic [14:0]        prev_th_q;
  logic [14:0]        prev_br_q;
  logic               prev_valid_q;

  // Working values of the current item.
  logic signed [15:0] st_q;
  logic [14:0] th_q, br_q, sp_q;
  logic        stamp_q;
  logic [17:0] sstep_q, pstep_q;
  logic [14:0] x_q, th_dz_q, br_dz_q;
  logic [14:0] r_q, p_q, s_q;

  // Divider.
  logic              dv_busy_q;
  logic [4:0]        dv_cnt_q;
  logic [28:0]       dv_quo_q;
  logic [15:0]       dv_rem_q;
  logic [14:0]       dv_den_q;
  jic_pkg::jic_div_e dv_sel_q;
  logic [28:0]       dv_num;
  logic [14:0]       dv_den;
  logic [15:0]       dv_shift;
  logic [16:0]       dv_trial;
  logic              dv_bit;
  logic [28:0]       dv_qfin;
  logic              dv_last;

  // Square root unit.
  logic        sq_busy_q;
  logic [28:0] sq_n_q, sq_res_q, sq_bit_q;
  logic [29:0] sq_sum;
  logic        sq_ge;
  logic [28:0] sq_n_nx, sq_res_nx;

  logic [9:0]  rate_eff;
  logic [14:0] a_st;
  logic [14:0] den_th, den_br;
  logic signed [15:0] st_clamp;
  logic [14:0] th_clamp, br_clamp;
  logic signed [19:0] st_lim, th_lim, br_lim;
  logic        slew_on;
  logic        exp_bit;

  assign rate_eff = (rate_q == 10'd0) ? 10'd1 : rate_q;
  assign a_st     = st_q[15] ? 15'(-st_q) : st_q[14:0];
  assign den_th   = 15'(ONE_W - {1'b0, tdz_q});
  assign den_br   = 15'(ONE_W - {1'b0, bdz_q});
  assign exp_bit  = exp_q[cmd_i.bit_idx];
  assign slew_on  = slew_en_q && prev_valid_q;

  always_comb begin
    if (steering_in_i > ONE_S) begin
      st_clamp = ONE_S;
    end else if (steering_in_i < -ONE_S) begin
      st_clamp = -ONE_S;
    end else begin
      st_clamp = steering_in_i;
    end
    if (throttle_in_i[15]) begin
      th_clamp = '0;
    end else if (throttle_in_i > ONE_S) begin
      th_clamp = ONE_U;
    end else begin
      th_clamp = throttle_in_i[14:0];
    end
    if (brake_in_i[15]) begin
      br_clamp = '0;
    end else if (brake_in_i > ONE_S) begin
      br_clamp = ONE_U;
    end else begin
      br_clamp = brake_in_i[14:0];
    end
  end

  assign st_lim = jic_pkg::slew_f(20'(st_q), 20'(prev_st_q), $signed({2'b00, sstep_q}));
  assign th_lim = jic_pkg::slew_f($signed({5'd0, th_q}), $signed({5'd0, prev_th_q}),
                                  $signed({2'b00, pstep_q}));
  assign br_lim = jic_pkg::slew_f($signed({5'd0, br_q}), $signed({5'd0, prev_br_q}),
                                  $signed({2'b00, pstep_q}));

  // Divider operand selection.
  always_comb begin
    dv_num = '0;
    dv_den = 15'd1;
    case (cmd_i.div_sel)
      jic_pkg::DV_SSTEP: begin
        dv_num = 29'(4 * jic_pkg::ONE) + 29'(rate_eff[9:1]);
        dv_den = 15'(rate_eff);
      end
      jic_pkg::DV_PSTEP: begin
        dv_num = 29'(8 * jic_pkg::ONE) + 29'(rate_eff[9:1]);
        dv_den = 15'(rate_eff);
      end
      jic_pkg::DV_DST: begin
        dv_den = ONE_U - SDZ_U;
        dv_num = (29'(a_st - SDZ_U) << jic_pkg::FRAC_BITS) + 29'(dv_den >> 1);
      end
      jic_pkg::DV_DTH: begin
        dv_den = den_th;
        dv_num = (29'(th_q - tdz_q) << jic_pkg::FRAC_BITS) + 29'(den_th >> 1);
      end
      jic_pkg::DV_DBR: begin
        dv_den = den_br;
        dv_num = (29'(br_q - bdz_q) << jic_pkg::FRAC_BITS) + 29'(den_br >> 1);
      end
      default: begin
        dv_num = '0;
        dv_den = 15'd1;
      end
    endcase
  end

  assign dv_shift = {dv_rem_q[14:0], dv_quo_q[28]};
  assign dv_trial = {1'b0, dv_shift} - {2'b00, dv_den_q};
  assign dv_bit   = !dv_trial[16];
  assign dv_qfin  = {dv_quo_q[27:0], dv_bit};
  assign dv_last  = dv_busy_q && (dv_cnt_q == 5'd1);

  assign sq_sum    = 30'(sq_res_q) + 30'(sq_bit_q);
  assign sq_ge     = {1'b0, sq_n_q} >= sq_sum;
  assign sq_n_nx   = sq_ge ? 29'(sq_n_q - sq_sum[28:0]) : sq_n_q;
  assign sq_res_nx = sq_ge ? 29'((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);

  assign stat_o.div_busy  = dv_busy_q;
  assign stat_o.sqrt_busy = sq_busy_q;

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q       <= 10'd100;
      slew_en_q    <= 1'b0;
      exp_q        <= 15'd4096;
      tdz_q        <= '0;
      bdz_q        <= '0;
      prev_st_q    <= '0;
      prev_th_q    <= '0;
      prev_br_q    <= '0;
      prev_valid_q <= 1'b0;
      dv_busy_q    <= 1'b0;
      dv_cnt_q     <= '0;
      sq_busy_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          jic_pkg::CFG_RATE:  rate_q    <= cfg_data_i[9:0];
          jic_pkg::CFG_SLEW:  slew_en_q <= cfg_data_i[0];
          jic_pkg::CFG_EXP:   exp_q     <= cfg_data_i;
          jic_pkg::CFG_TH_DZ: tdz_q     <= cfg_data_i;
          jic_pkg::CFG_BR_DZ: bdz_q     <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.slew) begin
        prev_st_q    <= slew_on ? st_lim[15:0] : st_q;
        prev_th_q    <= slew_on ? th_lim[14:0] : th_q;
        prev_br_q    <= slew_on ? br_lim[14:0] : br_q;
        prev_valid_q <= stamp_q;
      end
      if (cmd_i.div_start) begin
        dv_busy_q <= 1'b1;
        dv_cnt_q  <= 5'(jic_pkg::DIV_W);
      end else if (dv_busy_q) begin
        dv_cnt_q <= dv_cnt_q - 5'd1;
        if (dv_last) begin
          dv_busy_q <= 1'b0;
        end
      end
      if (cmd_i.sqrt_start) begin
        sq_busy_q <= 1'b1;
      end else if (sq_busy_q && sq_bit_q[0]) begin
        sq_busy_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      st_q    <= st_clamp;
      th_q    <= th_clamp;
      br_q    <= br_clamp;
      sp_q    <= speed_in_i[15] ? 15'd0 : speed_in_i[14:0];
      stamp_q <= stamp_valid_i;
    end
    if (cmd_i.slew && slew_on) begin
      st_q <= st_lim[15:0];
      th_q <= th_lim[14:0];
      br_q <= br_lim[14:0];
    end
    if (cmd_i.div_start) begin
      dv_quo_q <= dv_num;
      dv_rem_q <= '0;
      dv_den_q <= dv_den;
      dv_sel_q <= cmd_i.div_sel;
    end else if (dv_busy_q) begin
      dv_quo_q <= dv_qfin;
      dv_rem_q <= dv_bit ? dv_trial[15:0] : dv_shift;
    end
    if (dv_last) begin
      case (dv_sel_q)
        jic_pkg::DV_SSTEP: sstep_q <= dv_qfin[17:0];
        jic_pkg::DV_PSTEP: pstep_q <= dv_qfin[17:0];
        jic_pkg::DV_DST:   x_q <= (a_st < SDZ_U) ? 15'd0 : dv_qfin[14:0];
        jic_pkg::DV_DTH: begin
          if (tdz_q == 15'd0) begin
            th_dz_q <= th_q;
          end else if (tdz_q >= ONE_U || th_q < tdz_q) begin
            th_dz_q <= '0;
          end else begin
            th_dz_q <= dv_qfin[14:0];
          end
        end
        jic_pkg::DV_DBR: begin
          if (bdz_q == 15'd0) begin
            br_dz_q <= br_q;
          end else if (bdz_q >= ONE_U || br_q < bdz_q) begin
            br_dz_q <= '0;
          end else begin
            br_dz_q <= dv_qfin[14:0];
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.sqrt_start) begin
      sq_n_q   <= {s_q, 14'd0};
      sq_res_q <= '0;
      sq_bit_q <= 29'(1) << (jic_pkg::SQ_W - 1);
    end else if (sq_busy_q) begin
      sq_n_q   <= sq_n_nx;
      sq_res_q <= sq_res_nx;
      sq_bit_q <= sq_bit_q >> 2;
      if (sq_bit_q[0]) begin
        s_q <= sq_res_nx[14:0];
      end
    end
    if (cmd_i.curve_init) begin
      r_q <= ONE_U;
      p_q <= x_q;
      s_q <= x_q;
    end
    if ((cmd_i.mul_rp && exp_bit)) begin
      r_q <= jic_pkg::qmul_f(r_q, p_q);
    end
    if (cmd_i.mul_rs && exp_bit) begin
      r_q <= jic_pkg::qmul_f(r_q, s_q);
    end
    if (cmd_i.sq_p) begin
      p_q <= jic_pkg::qmul_f(p_q, p_q);
    end
    if (cmd_i.out_load) begin
      if (x_q == 15'd0) begin
        steering_out_o <= '0;
      end else begin
        steering_out_o <= st_q[15] ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
      end
      throttle_out_o <= th_dz_q;
      brake_out_o    <= br_dz_q;
      speed_out_o    <= sp_q;
    end
  end

  // The two iterative units are never started together.
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dv_busy_q && sq_busy_q)) else $error("divider and square root busy together");

endmodule

[rtl/core/jic_ctrl.sv]
// Sequencer of the joystick input conditioner: handshakes and command sequence.
// Depends on jic_pkg; drives jic_dp through command and status structs.
module jic_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  jic_pkg::jic_stat_t stat_i,
  output jic_pkg::jic_cmd_t  cmd_o
);

  jic_pkg::jic_state_e state_q, state_d;
  logic [3:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jic_pkg::S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.bit_idx = idx_q;
    cmd_o.div_sel = jic_pkg::DV_SSTEP;
    unique case (state_q)
      jic_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = jic_pkg::S_SSTEP;
        end
      end
      jic_pkg::S_SSTEP: begin
        cmd_o.div_start = 1'b1;
        state_d         = jic_pkg::S_SSTEP_W;
      end
      jic_pkg::S_SSTEP_W: if (!stat_i.div_busy) state_d = jic_pkg::S_PSTEP;
      jic_pkg::S_PSTEP: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = jic_pkg::DV_PSTEP;
        state_d         = jic_pkg::S_PSTEP_W;
      end
      jic_pkg::S_PSTEP_W: if (!stat_i.div_busy) state_d = jic_pkg::S_SLEW;
      jic_pkg::S_SLEW: begin
        cmd_o.slew = 1'b1;
        state_d    = jic_pkg::S_DST;
      end
      jic_pkg::S_DST: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = jic_pkg::DV_DST;
        state_d         = jic_pkg::S_DST_W;
      end
      jic_pkg::S_DST_W: if (!stat_i.div_busy) state_d = jic_pkg::S_DTH;
      jic_pkg::S_DTH: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = jic_pkg::DV_DTH;
        state_d         = jic_pkg::S_DTH_W;
      end
      jic_pkg::S_DTH_W: if (!stat_i.div_busy) state_d = jic_pkg::S_DBR;
      jic_pkg::S_DBR: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = jic_pkg::DV_DBR;
        state_d         = jic_pkg::S_DBR_W;
      end
      jic_pkg::S_DBR_W: if (!stat_i.div_busy) state_d = jic_pkg::S_CINIT;
      jic_pkg::S_CINIT: begin
        cmd_o.curve_init = 1'b1;
        idx_d            = jic_pkg::IDX_INT_LO;
        state_d          = jic_pkg::S_MRP;
      end
      jic_pkg::S_MRP: begin
        cmd_o.mul_rp = 1'b1;
        state_d      = jic_pkg::S_SQP;
      end
      jic_pkg::S_SQP: begin
        cmd_o.sq_p = 1'b1;
        if (idx_q == jic_pkg::IDX_INT_HI) begin
          idx_d   = jic_pkg::IDX_FRAC_HI;
          state_d = jic_pkg::S_SQRT;
        end else begin
          idx_d   = idx_q + 4'd1;
          state_d = jic_pkg::S_MRP;
        end
      end
      jic_pkg::S_SQRT: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = jic_pkg::S_SQRT_W;
      end
      jic_pkg::S_SQRT_W: if (!stat_i.sqrt_busy) state_d = jic_pkg::S_MRS;
      jic_pkg::S_MRS: begin
        cmd_o.mul_rs = 1'b1;
        if (idx_q == 4'd0) begin
          state_d = jic_pkg::S_OUT;
        end else begin
          idx_d   = idx_q - 4'd1;
          state_d = jic_pkg::S_SQRT;
        end
      end
      jic_pkg::S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = jic_pkg::S_IDLE;
        end
      end
      default: state_d = jic_pkg::S_IDLE;
    endcase
  end

  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !stat_i.div_busy) else $error("divider started while busy");

  a_sqrt_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sqrt_start |-> !stat_i.sqrt_busy) else $error("square root started while busy");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == jic_pkg::S_SSTEP))
    else $error("accepted transfer did not start the sequence");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_o) else $error("result loaded but not presented");

endmodule

[rtl/core/joystick_input_conditioner.sv]
// Top level of the joystick input conditioner: handshake ports and wiring.
// Depends on jic_pkg, jic_ctrl and jic_dp.
//
// Usage: one operator sample is a transfer on the input channel (in_valid_i,
// in_ready_o) carrying steering, throttle, brake, target speed and the
// timestamp-valid flag. Each sample yields exactly one result transfer on the
// output channel (out_valid_o, out_ready_i). Configuration registers are
// written through the cfg channel by index (0 rate, 1 slew enable, 2 curve
// exponent, 3 throttle deadzone, 4 brake deadzone); cfg_ready_o is always
// high and writes are meant for times when no sample is in flight.
// Sequencing: no new sample is taken before the previous result has been
// loaded into the output register; the block then returns to idle and takes
// the next sample on the following cycle. The work per sample is set by the
// shared restoring divider (five divisions: two slew steps and three deadzone
// rescales) and the shared square root unit (twelve roots, each followed by
// one multiply, for the fractional exponent).
// Reset clears the slew history, so the first sample passes unlimited, and
// loads the register defaults. When the receiver stalls, the result waits in
// the output register while the next sample is already processed; only its
// final load waits until the output register has been emptied.
module joystick_input_conditioner (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [14:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] steering_in_i,
  input  logic signed [15:0] throttle_in_i,
  input  logic signed [15:0] brake_in_i,
  input  logic signed [15:0] speed_in_i,
  input  logic               stamp_valid_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] steering_out_o,
  output logic [14:0]        throttle_out_o,
  output logic [14:0]        brake_out_o,
  output logic [14:0]        speed_out_o
);

  jic_pkg::jic_cmd_t  cmd;
  jic_pkg::jic_stat_t stat;

  // Registers accept a write on every cycle.
  assign cfg_ready_o = 1'b1;

  jic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  jic_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .steering_in_i  (steering_in_i),
    .throttle_in_i  (throttle_in_i),
    .brake_in_i     (brake_in_i),
    .speed_in_i     (speed_in_i),
    .stamp_valid_i  (stamp_valid_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .steering_out_o (steering_out_o),
    .throttle_out_o (throttle_out_o),
    .brake_out_o    (brake_out_o),
    .speed_out_o    (speed_out_o)
  );

endmodule
